@@ rtl/core/ibim_pkg.sv @@
// Shared types and constants for the I/O busy/idle monitor.
// No dependencies; used by io_busy_idle_monitor.
package ibim_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TIME_W      = 48;
    localparam int TALLY_W     = 32;
    localparam int DELAY_W     = 16;
    localparam int NUM_BINS    = 9;
    localparam int BIN_IDX_W   = $clog2(NUM_BINS);

    localparam logic [TIME_W-1:0]      STUCK_LIMIT_MS = TIME_W'(3600000);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = '1;
    localparam logic [DELAY_W-1:0]     DELAY_RESET    = DELAY_W'(10);

    // upper bounds (exclusive) of the first eight bins; last bin takes the rest
    localparam logic [TIME_W-1:0] BIN_BOUNDS [NUM_BINS-1] = '{
        TIME_W'(100),  TIME_W'(500),  TIME_W'(1000), TIME_W'(2000),
        TIME_W'(4000), TIME_W'(6000), TIME_W'(8000), TIME_W'(10000)
    };

    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_END   = 2'd1,
        FN_TICK  = 2'd2,
        FN_READ  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_BUSY = 2'd1,
        EV_IDLE = 2'd2
    } event_t;

    typedef enum logic {
        REG_NOTIFY_ENABLE = 1'b0,
        REG_IDLE_DELAY    = 1'b1
    } cfg_reg_t;

    function automatic logic [BIN_IDX_W-1:0] bin_of(input logic [TIME_W-1:0] span);
        logic [BIN_IDX_W-1:0] b;
        b = BIN_IDX_W'(NUM_BINS - 1);
        for (int i = NUM_BINS - 2; i >= 0; i--) begin
            if (span < BIN_BOUNDS[i])
                b = BIN_IDX_W'(i);
        end
        return b;
    endfunction

endpackage

@@ rtl/core/io_busy_idle_monitor.sv @@
// I/O busy/idle monitor: outstanding-I/O count, busy/idle events, time stats, histogram.
// Depends on ibim_pkg.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+--------------------------------------------
//   req      | in        | req_valid/stall   | func, bin_index
//   rsp      | out       | rsp_valid/stall   | event_res .. bin_count (ten fields)
//   cfg      | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// One item per cycle sustained while rsp is not stalled; an item passes the input
// register, then the update stage that writes state and the result register.
// Reset clears all monitor state; notify_enable resets to 0 and idle_delay_ms to 10.
// A stall on rsp holds the result and backs up into req_stall the same cycle.
// cfg_ready is always high.
module io_busy_idle_monitor
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    func,
    input  logic [3:0]                    bin_index,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [1:0]                    event_res,
    output logic                          underflow,
    output logic                          stuck_busy,
    output logic [15:0]                   outstanding,
    output logic                          is_busy,
    output logic [47:0]                   busy_total_ms,
    output logic [47:0]                   idle_total_ms,
    output logic [31:0]                   idle_entries,
    output logic [47:0]                   longest_idle_ms,
    output logic [31:0]                   bin_count,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [15:0]                   cfg_data
);

    // configuration
    logic                              enable_reg;
    logic [ibim_pkg::DELAY_W-1:0]      delay_cfg_reg;

    // input stage
    logic                              s1_valid_reg;
    ibim_pkg::func_t                   s1_func_reg;
    logic [3:0]                        s1_bin_reg;

    // monitor state; elapsed counters stand for now_ms - *_since
    logic [ibim_pkg::COUNT_WIDTH-1:0]  pending_reg,    pending_next;
    logic                              busy_reg,       busy_next;
    logic [ibim_pkg::DELAY_W-1:0]      delay_left_reg, delay_left_next;
    logic                              armed_reg,      armed_next;
    logic [ibim_pkg::TIME_W-1:0]       busy_el_reg,    busy_el_next;
    logic [ibim_pkg::TIME_W-1:0]       idle_el_reg,    idle_el_next;
    logic                              busy_seen_reg,  busy_seen_next;
    logic                              idle_seen_reg,  idle_seen_next;
    logic [ibim_pkg::TIME_W-1:0]       busy_sum_reg,   busy_sum_next;
    logic [ibim_pkg::TIME_W-1:0]       idle_sum_reg,   idle_sum_next;
    logic [ibim_pkg::TALLY_W-1:0]      tally_reg,      tally_next;
    logic [ibim_pkg::TIME_W-1:0]       idle_max_reg,   idle_max_next;
    logic [ibim_pkg::TALLY_W-1:0]      hist_reg [ibim_pkg::NUM_BINS];
    logic                              hist_we;
    logic [ibim_pkg::BIN_IDX_W-1:0]    hist_idx;

    // result register
    logic                              rsp_valid_reg;
    ibim_pkg::event_t                  event_reg,      event_next;
    logic                              under_reg,      under_next;
    logic                              stuck_reg,      stuck_next;
    logic [ibim_pkg::TALLY_W-1:0]      bin_reg,        bin_next;

    logic                              advance;
    logic                              fire;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = s1_valid_reg && advance;
    assign req_stall = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            delay_cfg_reg <= ibim_pkg::DELAY_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (ibim_pkg::cfg_reg_t'(cfg_index))
                ibim_pkg::REG_NOTIFY_ENABLE: enable_reg    <= cfg_data[0];
                ibim_pkg::REG_IDLE_DELAY:    delay_cfg_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!req_stall)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            s1_func_reg <= ibim_pkg::func_t'(func);
            s1_bin_reg  <= bin_index;
        end
    end

    always_comb
    begin
        pending_next    = pending_reg;
        busy_next       = busy_reg;
        delay_left_next = delay_left_reg;
        armed_next      = armed_reg;
        busy_el_next    = busy_el_reg;
        idle_el_next    = idle_el_reg;
        busy_seen_next  = busy_seen_reg;
        idle_seen_next  = idle_seen_reg;
        busy_sum_next   = busy_sum_reg;
        idle_sum_next   = idle_sum_reg;
        tally_next      = tally_reg;
        idle_max_next   = idle_max_reg;
        hist_we         = 1'b0;
        hist_idx        = ibim_pkg::bin_of(idle_el_reg);
        event_next      = ibim_pkg::EV_NONE;
        under_next      = 1'b0;
        stuck_next      = 1'b0;
        bin_next        = '0;

        unique case (s1_func_reg)
            ibim_pkg::FN_START:
            begin
                if (pending_reg != ibim_pkg::COUNT_MAX)
                begin
                    pending_next = pending_reg + 1'b1;
                    if (enable_reg && pending_reg == '0)
                    begin
                        armed_next      = 1'b0;
                        delay_left_next = '0;
                        if (!busy_reg)
                        begin
                            busy_next      = 1'b1;
                            busy_el_next   = '0;
                            busy_seen_next = 1'b1;
                            event_next     = ibim_pkg::EV_BUSY;
                            if (idle_seen_reg)
                            begin
                                // span of the idle period just closed
                                hist_we       = 1'b1;
                                idle_sum_next = idle_sum_reg + idle_el_reg;
                                if (idle_el_reg > idle_max_reg)
                                    idle_max_next = idle_el_reg;
                            end
                        end
                    end
                end
                // busy just entered means zero elapsed, never stuck
                stuck_next = enable_reg && busy_seen_reg && (event_next == ibim_pkg::EV_NONE)
                             && (busy_el_reg > ibim_pkg::STUCK_LIMIT_MS);
            end
            ibim_pkg::FN_END:
            begin
                if (pending_reg == '0)
                    under_next = enable_reg;
                else
                begin
                    pending_next = pending_reg - 1'b1;
                    if (enable_reg && pending_reg == ibim_pkg::COUNT_WIDTH'(1) && !armed_reg)
                    begin
                        armed_next      = 1'b1;
                        delay_left_next = delay_cfg_reg;
                    end
                end
            end
            ibim_pkg::FN_TICK:
            begin
                busy_el_next = busy_el_reg + 1'b1;
                idle_el_next = idle_el_reg + 1'b1;
                if (armed_reg)
                begin
                    if (delay_left_reg <= ibim_pkg::DELAY_W'(1))
                    begin
                        armed_next      = 1'b0;
                        delay_left_next = '0;
                        if (pending_reg == '0 && busy_reg)
                        begin
                            busy_next      = 1'b0;
                            tally_next     = tally_reg + 1'b1;
                            idle_el_next   = '0;
                            idle_seen_next = 1'b1;
                            event_next     = ibim_pkg::EV_IDLE;
                            // busy span includes this tick: add with carry-in
                            if (busy_seen_reg)
                                busy_sum_next = busy_sum_reg + busy_el_reg + 1'b1;
                        end
                    end
                    else
                        delay_left_next = delay_left_reg - 1'b1;
                end
            end
            ibim_pkg::FN_READ:
            begin
                if (s1_bin_reg < 4'(ibim_pkg::NUM_BINS))
                    bin_next = hist_reg[ibim_pkg::BIN_IDX_W'(s1_bin_reg)];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            busy_reg       <= 1'b0;
            delay_left_reg <= '0;
            armed_reg      <= 1'b0;
            busy_el_reg    <= '0;
            idle_el_reg    <= '0;
            busy_seen_reg  <= 1'b0;
            idle_seen_reg  <= 1'b0;
            busy_sum_reg   <= '0;
            idle_sum_reg   <= '0;
            tally_reg      <= '0;
            idle_max_reg   <= '0;
            for (int i = 0; i < ibim_pkg::NUM_BINS; i++)
                hist_reg[i] <= '0;
        end
        else if (fire)
        begin
            pending_reg    <= pending_next;
            busy_reg       <= busy_next;
            delay_left_reg <= delay_left_next;
            armed_reg      <= armed_next;
            busy_el_reg    <= busy_el_next;
            idle_el_reg    <= idle_el_next;
            busy_seen_reg  <= busy_seen_next;
            idle_seen_reg  <= idle_seen_next;
            busy_sum_reg   <= busy_sum_next;
            idle_sum_reg   <= idle_sum_next;
            tally_reg      <= tally_next;
            idle_max_reg   <= idle_max_next;
            if (hist_we)
                hist_reg[hist_idx] <= hist_reg[hist_idx] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            event_reg <= event_next;
            under_reg <= under_next;
            stuck_reg <= stuck_next;
            bin_reg   <= bin_next;
        end
    end

    // state only moves on a transfer into the result register, so it holds under stall
    assign rsp_valid       = rsp_valid_reg;
    assign event_res       = event_reg;
    assign underflow       = under_reg;
    assign stuck_busy      = stuck_reg;
    assign outstanding     = 16'(pending_reg);
    assign is_busy         = busy_reg;
    assign busy_total_ms   = busy_sum_reg;
    assign idle_total_ms   = idle_sum_reg;
    assign idle_entries    = tally_reg;
    assign longest_idle_ms = idle_max_reg;
    assign bin_count       = bin_reg;

    a_idle_event: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && event_reg == ibim_pkg::EV_IDLE |-> !busy_reg && pending_reg == '0)
        else $error("idle event with busy state or I/O outstanding");

    a_busy_event: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && event_reg == ibim_pkg::EV_BUSY
            |-> busy_reg && pending_reg == ibim_pkg::COUNT_WIDTH'(1))
        else $error("busy event without single outstanding I/O");

    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && under_reg |-> pending_reg == '0 && event_reg == ibim_pkg::EV_NONE)
        else $error("underflow with I/O outstanding");

    a_busy_seen: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> busy_seen_reg)
        else $error("busy state without recorded busy start");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_stall |=> $stable(pending_reg) && $stable(busy_sum_reg))
        else $error("state moved while result stalled");

endmodule
